// ===== rtl/core/fpfa_pkg.sv =====
// types and constants shared by the fixed partition fit allocator
package fpfa_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/fixed_partition_fit_allocator_core.sv =====
// fixed partition allocator: size table, used bits and a sequential fit scan
//
//  channel | direction | handshake               | word
//  in      | input     | i_in_valid / o_in_ready  | i_op, i_slot_index, i_size_value
//  out     | output    | o_out_valid / i_out_ready| o_granted, o_granted_slot, o_granted_size
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// load, free-all and unused op words go straight to S_DONE, which registers the result
// an allocate word walks one table slot per cycle through the size memory read port,
// up to limit slots, then goes to S_DONE, which registers its result word,
// with limit = min(block_count, MAX_BLOCKS)
// the block takes no new word until the current one has reached the output register
// a result held by i_out_ready low stalls only the final step; cfg writes are always taken
// reset frees every block and clears fit_mode and block_count; sizes are undefined until loaded
module fixed_partition_fit_allocator_core #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [fpfa_pkg::OP_W-1:0]       i_op,
    input  logic [fpfa_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic [fpfa_pkg::SIZE_W-1:0]     i_size_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_granted,
    output logic [fpfa_pkg::SLOT_W-1:0]     o_granted_slot,
    output logic [fpfa_pkg::SIZE_W-1:0]     o_granted_size,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fpfa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [SIZE_W-1:0]     mem [MAX_BLOCKS];
    logic [SIZE_W-1:0]     r_rd_data;

    t_state                r_state, n_state;
    logic                  r_out_valid, n_out_valid;
    logic [MAX_BLOCKS-1:0] r_used;
    logic [MODE_W-1:0]     r_fit_mode;
    logic [COUNT_W-1:0]    r_block_count;

    logic [CW-1:0]         r_idx, n_idx;
    logic [LW-1:0]         r_limit, n_limit;
    logic                  r_chk_v, n_chk_v;
    logic [IW-1:0]         r_chk_idx, n_chk_idx;
    logic [SIZE_W-1:0]     r_want, n_want;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_best_idx, n_best_idx;
    logic [SIZE_W-1:0]     r_best_size, n_best_size;
    logic                  r_granted, n_granted;
    logic [SLOT_W-1:0]     r_gslot, n_gslot;
    logic [SIZE_W-1:0]     r_gsize, n_gsize;

    logic                  rd_en, mem_we, clr_used, set_used, issue, fit, take;
    logic                  slot_ok;
    logic [LW-1:0]         cnt_ext, limit_c;

    assign slot_ok  = 32'(i_slot_index) < MAX_BLOCKS;
    assign cnt_ext  = LW'(r_block_count);
    assign limit_c  = (cnt_ext > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : cnt_ext;
    assign issue    = LW'(r_idx) < r_limit;
    assign fit      = r_chk_v && !r_used[r_chk_idx] && (r_rd_data >= r_want);

    always_comb begin
        priority if (!r_found) begin
            take = 1'b1;
        end else if (r_fit_mode == FIT_BEST) begin
            take = r_rd_data < r_best_size;
        end else if (r_fit_mode == FIT_WORST) begin
            take = r_rd_data > r_best_size;
        end else begin
            take = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_idx       = r_idx;
        n_limit     = r_limit;
        n_chk_v     = r_chk_v;
        n_chk_idx   = r_chk_idx;
        n_want      = r_want;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_size = r_best_size;
        n_granted   = r_granted;
        n_gslot     = r_gslot;
        n_gsize     = r_gsize;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        clr_used    = 1'b0;
        set_used    = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_found     = 1'b0;
                    n_best_idx  = '0;
                    n_best_size = '0;
                    n_idx       = '0;
                    n_chk_v     = 1'b0;
                    n_limit     = limit_c;
                    n_want      = i_size_value;
                    n_state     = S_DONE;
                    unique case (i_op)
                        OP_ALLOC: n_state = S_SCAN;
                        OP_LOAD:  mem_we = slot_ok;
                        OP_FREE:  clr_used = 1'b1;
                        default:  ;
                    endcase
                end
            end
            S_SCAN: begin
                rd_en     = issue;
                n_chk_v   = issue;
                n_chk_idx = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (fit && take) begin
                    n_found     = 1'b1;
                    n_best_idx  = r_chk_idx;
                    n_best_size = r_rd_data;
                end
                if (!issue && !r_chk_v) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_granted   = r_found;
                    n_gslot     = SLOT_W'(r_best_idx);
                    n_gsize     = r_best_size;
                    set_used    = r_found;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
            r_used      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chk_v     <= n_chk_v;
            if (clr_used) begin
                r_used <= '0;
            end else if (set_used) begin
                r_used[r_best_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_limit     <= n_limit;
        r_chk_idx   <= n_chk_idx;
        r_want      <= n_want;
        r_found     <= n_found;
        r_best_idx  <= n_best_idx;
        r_best_size <= n_best_size;
        r_granted   <= n_granted;
        r_gslot     <= n_gslot;
        r_gsize     <= n_gsize;
    end

    // size table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[IW'(i_slot_index)] <= i_size_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= '0;
            r_block_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_granted;
    assign o_granted_slot = r_gslot;
    assign o_granted_size = r_gsize;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the fixed partition fit allocator core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    localparam int NUM_BLOCKS   = 16;
    localparam int RANDOM_WORDS = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 25;
    localparam int STALL_LIMIT  = 4000;

    localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0]    FIT_FIRST    = 2'd0;
    localparam logic [MODE_W-1:0]    FIT_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] size;
    } t_grant;

    class alloc_scoreboard;
        logic [SIZE_W-1:0]  block_size [NUM_BLOCKS];
        bit                 block_used [NUM_BLOCKS];
        logic [MODE_W-1:0]  fit_mode;
        logic [COUNT_W-1:0] block_count;
        t_grant             expected_grants [$];
        int                 errors;

        function new();
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                block_size[i] = '0;
                block_used[i] = 1'b0;
            end
            fit_mode    = '0;
            block_count = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FIT_MODE) begin
                fit_mode = data[MODE_W-1:0];
            end else if (idx == CFG_BLOCK_COUNT) begin
                block_count = data[COUNT_W-1:0];
            end
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                logic [SIZE_W-1:0] size);
            t_grant g;
            int     limit;
            int     chosen;
            bit     stop;
            g = '0;
            case (op)
                OP_LOAD: begin
                    block_size[slot] = size;
                end
                OP_FREE: begin
                    for (int i = 0; i < NUM_BLOCKS; i++) block_used[i] = 1'b0;
                end
                OP_ALLOC: begin
                    limit  = (block_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
                    chosen = -1;
                    stop   = 1'b0;
                    for (int i = 0; i < limit; i++) begin
                        if (!stop && !block_used[i] && block_size[i] >= size) begin
                            if (chosen < 0) begin
                                chosen = i;
                                if (fit_mode != FIT_BEST && fit_mode != FIT_WORST) stop = 1'b1;
                            end else if (fit_mode == FIT_BEST &&
                                         block_size[i] < block_size[chosen]) begin
                                chosen = i;
                            end else if (fit_mode == FIT_WORST &&
                                         block_size[i] > block_size[chosen]) begin
                                chosen = i;
                            end
                        end
                    end
                    if (chosen >= 0) begin
                        block_used[chosen] = 1'b1;
                        g.granted = 1'b1;
                        g.slot    = chosen[SLOT_W-1:0];
                        g.size    = block_size[chosen];
                    end
                end
                default: ;
            endcase
            expected_grants.push_back(g);
        endfunction

        task report_mismatch(string field, int got, int want);
            $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
            errors++;
        endtask

        task check_grant(logic granted, logic [SLOT_W-1:0] slot, logic [SIZE_W-1:0] size);
            t_grant want;
            if (expected_grants.size() == 0) begin
                report_mismatch("unexpected result word", granted, 0);
            end else begin
                want = expected_grants.pop_front();
                if (granted !== want.granted) report_mismatch("granted", granted, want.granted);
                if (slot !== want.slot) report_mismatch("granted_slot", slot, want.slot);
                if (size !== want.size) report_mismatch("granted_size", size, want.size);
            end
        endtask

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [OP_W-1:0]       op         = '0;
    logic [SLOT_W-1:0]     slot_index = '0;
    logic [SIZE_W-1:0]     size_value = '0;
    logic                  out_ready  = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_granted;
    logic [SLOT_W-1:0]     o_granted_slot;
    logic [SIZE_W-1:0]     o_granted_size;
    logic                  o_cfg_ready;

    alloc_scoreboard sb = new();

    int tx_idle_pct = 11;
    int rx_idle_pct = 11;
    int hold_ticket = 0;
    int words_sent  = 0;
    int quiet_count = 0;

    fixed_partition_fit_allocator_core #(.MAX_BLOCKS(NUM_BLOCKS)) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (op),
        .i_slot_index   (slot_index),
        .i_size_value   (size_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_granted      (o_granted),
        .o_granted_slot (o_granted_slot),
        .o_granted_size (o_granted_size),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && o_in_ready) sb.note_word(op, slot_index, size_value);
            if (o_out_valid && out_ready) sb.check_grant(o_granted, o_granted_slot,
                                                         o_granted_size);
            if (cfg_valid && o_cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
                (cfg_valid && o_cfg_ready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    // result side: random stalls plus one long hold on request
    initial begin
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        forever begin
            @(posedge clk);
            if (hold_ticket != seen) begin
                seen = hold_ticket;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task send_word(logic [OP_W-1:0] w_op, logic [SLOT_W-1:0] w_slot,
                   logic [SIZE_W-1:0] w_size);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= w_op;
        slot_index <= w_slot;
        size_value <= w_size;
        do @(posedge clk); while (!o_in_ready);
        words_sent++;
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_load_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return SIZE_W'($urandom_range(0, 64));
        if (r < 55) return '0;
        if (r < 60) return '1;
        return SIZE_W'($urandom);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return SIZE_W'($urandom_range(0, 8));
        if (r < 75) return sb.block_size[$urandom_range(0, NUM_BLOCKS - 1)]
                           + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
        return SIZE_W'($urandom);
    endfunction

    initial begin
        logic [MODE_W-1:0]     mode;
        logic [CFG_DATA_W-1:0] count;
        int                    n;
        int                    r;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(CFG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
        write_cfg(CFG_BLOCK_COUNT, CFG_DATA_W'(NUM_BLOCKS));
        send_word(OP_LOAD, 4'd0, 16'h0000);
        send_word(OP_LOAD, 4'd1, 16'hFFFF);
        send_word(OP_LOAD, 4'd2, 16'h5555);
        send_word(OP_LOAD, 4'd3, 16'hAAAA);
        send_word(OP_LOAD, 4'd4, 16'd100);
        send_word(OP_LOAD, 4'd5, 16'd100);
        send_word(OP_LOAD, 4'd6, 16'd50);
        for (int i = 7; i < NUM_BLOCKS; i++) send_word(OP_LOAD, SLOT_W'(i), SIZE_W'(i * 37));
        send_word(OP_ALLOC, 4'd9, 16'h0000);
        send_word(OP_ALLOC, 4'd0, 16'hFFFF);
        send_word(OP_ALLOC, 4'd15, 16'hFFFF);
        send_word(OP_ALLOC, 4'd0, 16'd100);
        send_word(OP_UNUSED, 4'd15, 16'hFFFF);
        send_word(OP_FREE, 4'd7, 16'h1234);

        for (int p = 0; words_sent < RANDOM_WORDS + 22; p++) begin
            wait_drain();
            if (p == 3) begin
                write_cfg(CFG_SPARE_LO, '1);
                write_cfg(CFG_SPARE_HI, '1);
            end
            case (p)
                0: begin mode = FIT_BEST;   count = 5'd16; end
                1: begin mode = FIT_WORST;  count = 5'd16; end
                2: begin mode = FIT_UNUSED; count = 5'd31; end
                3: begin mode = FIT_FIRST;  count = 5'd0;  end
                4: begin mode = FIT_BEST;   count = 5'd1;  end
                5: begin mode = FIT_WORST;  count = 5'd17; end
                6: begin mode = FIT_FIRST;  count = 5'd16; end
                default: begin
                    mode  = MODE_W'($urandom_range(0, 3));
                    count = ($urandom_range(0, 99) < 70) ? 5'd16
                                                         : COUNT_W'($urandom_range(0, 31));
                end
            endcase
            write_cfg(CFG_FIT_MODE, {3'($urandom_range(0, 7)), mode});
            write_cfg(CFG_BLOCK_COUNT, count);

            tx_idle_pct = (p >= 10 && p < 20) ? 0 : 11;
            rx_idle_pct = tx_idle_pct;
            if (p == 5) hold_ticket++;

            send_word(OP_FREE, SLOT_W'($urandom), SIZE_W'($urandom));
            n = $urandom_range(15, 40);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    send_word(OP_LOAD, SLOT_W'($urandom), pick_load_size());
                end else if (r < 14) begin
                    send_word(OP_FREE, SLOT_W'($urandom), SIZE_W'($urandom));
                end else if (r < 17) begin
                    send_word(OP_UNUSED, SLOT_W'($urandom), SIZE_W'($urandom));
                end else begin
                    send_word(OP_ALLOC, SLOT_W'($urandom), pick_request());
                end
            end
        end

        wait_drain();
        repeat (40) @(posedge clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fpfa_pkg.sv
rtl/core/fixed_partition_fit_allocator_core.sv
verif/tb_top.sv
